>>> rtl/vrms_pkg.sv
// ----------------------------------------------------------------------------
// vrms_pkg: shared types and constants
// Word formats, datapath widths and back-end states for the vector RMS block.
// ----------------------------------------------------------------------------
package vrms_pkg;

	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned MAX_LEN_DEF = 65536;
	localparam int unsigned SQ_W        = 2 * SAMPLE_BITS;
	localparam int unsigned SUM_W       = 47;
	localparam int unsigned FRAC_BITS   = 16;
	localparam int unsigned DIVIDEND_W  = SUM_W + FRAC_BITS;
	localparam int unsigned RAD_W       = 64;
	localparam int unsigned ROOT_W      = RAD_W / 2;
	localparam int unsigned SQREM_W     = ROOT_W + 2;
	localparam int unsigned RMS_W       = 24;
	localparam int unsigned COUNT_W     = 17;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          is_last;
	} in_word_t;

	typedef struct packed {
		logic [RMS_W-1:0]   rms_value;
		logic [COUNT_W-1:0] element_count;
		logic               overflowed;
	} out_word_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT,
		BK_HOLD
	} back_state_t;

	typedef struct packed {
		logic pop;
		logic load_div;
		logic load_sqrt;
		logic load_out;
	} back_ctrl_t;

endpackage

>>> rtl/vrms_stream_if.sv
// ----------------------------------------------------------------------------
// vrms_stream_if: valid/ready channel
// Carries one word of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface vrms_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/vrms_front.sv
// ----------------------------------------------------------------------------
// vrms_front: sample intake and accumulation
// Squares each sample, keeps the saturating sum of squares and the count, and
// hands the totals of a finished vector to the queue.
// ----------------------------------------------------------------------------
module vrms_front #(
	parameter int unsigned MAX_LEN = vrms_pkg::MAX_LEN_DEF,
	parameter int unsigned CNT_W   = $clog2(MAX_LEN + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	vrms_stream_if.sink              samples,
	output logic                     push,
	input  logic                     push_ready,
	output logic [vrms_pkg::SUM_W-1:0] rec_sum,
	output logic [CNT_W-1:0]         rec_count,
	output logic                     rec_ovf
);
	import vrms_pkg::*;

	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SQ_W-1:0]        sq_s1;
	logic                   last_s1;
	logic                   valid_s1;
	logic                   advance;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       count_q;
	logic                   ovf_q;
	logic [SUM_W:0]         sum_add;
	logic                   at_max;

	assign raw = samples.data.sample;
	assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

	assign advance       = valid_s1 && (!last_s1 || push_ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sq_s1   <= mag * mag;
			last_s1 <= samples.data.is_last;
		end
	end

	always_comb begin
		at_max  = (count_q == CNT_W'(MAX_LEN));
		sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sq_s1);
		if (at_max) begin
			rec_sum   = sum_q;
			rec_count = count_q;
		end else begin
			rec_sum   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
			rec_count = count_q + CNT_W'(1);
		end
		rec_ovf = ovf_q | at_max;
	end

	assign push = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				sum_q   <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				sum_q   <= rec_sum;
				count_q <= rec_count;
				ovf_q   <= rec_ovf;
			end
		end
	end

endmodule

>>> rtl/vrms_fifo.sv
// ----------------------------------------------------------------------------
// vrms_fifo: short queue between front and back
// Holds the totals of finished vectors until the back end takes them.
// ----------------------------------------------------------------------------
module vrms_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);
	import vrms_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != FILL_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

>>> rtl/vrms_back.sv
// ----------------------------------------------------------------------------
// vrms_back: mean and square root
// Divides the scaled sum of squares by the count one quotient bit per cycle,
// takes the integer square root one root bit per cycle, and holds the result
// word in an output register.
// ----------------------------------------------------------------------------
module vrms_back #(
	parameter int unsigned CNT_W = 17
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rec_valid,
	output logic                                 rec_pop,
	input  logic [vrms_pkg::SUM_W+CNT_W:0]       rec_data,
	vrms_stream_if.source                        results
);
	import vrms_pkg::*;

	localparam int unsigned STEP_W = $clog2(DIVIDEND_W);

	back_state_t           state_q;
	back_state_t           state_next;
	back_ctrl_t            ctrl;
	logic [STEP_W-1:0]     step_q;
	logic                  div_last;
	logic                  sqrt_last;

	logic [SUM_W-1:0]      in_sum;
	logic [CNT_W-1:0]      in_count;
	logic                  in_ovf;

	logic [DIVIDEND_W-1:0] dq_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      div_q;
	logic                  ovf_q;
	logic [CNT_W:0]        rem_shift;
	logic                  rem_ge;
	logic [CNT_W:0]        rem_diff;
	logic [DIVIDEND_W-1:0] dq_next;

	logic [RAD_W-1:0]      rad_q;
	logic [SQREM_W-1:0]    sqrem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQREM_W+1:0]    sq_trial;
	logic [SQREM_W+1:0]    sq_test;
	logic                  sq_ge;
	logic [SQREM_W+1:0]    sq_diff;
	logic [ROOT_W-1:0]     root_next;

	logic [CNT_W+COUNT_W-1:0] count_ext;
	logic                  out_valid_q;
	out_word_t             out_q;

	assign {in_sum, in_count, in_ovf} = rec_data;

	assign div_last  = (step_q == STEP_W'(DIVIDEND_W - 1));
	assign sqrt_last = (step_q == STEP_W'(ROOT_W - 1));

	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: if (rec_valid) state_next = BK_DIV;
			BK_DIV:  if (div_last) state_next = BK_SQRT;
			BK_SQRT: if (sqrt_last) state_next = BK_HOLD;
			BK_HOLD: if (!out_valid_q || results.ready) state_next = BK_IDLE;
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			BK_IDLE: begin
				ctrl.pop      = rec_valid;
				ctrl.load_div = rec_valid;
			end
			BK_DIV:  ctrl.load_sqrt = div_last;
			BK_SQRT: ctrl.load_sqrt = 1'b0;
			BK_HOLD: ctrl.load_out = !out_valid_q || results.ready;
			default: ctrl = '0;
		endcase
	end

	assign rec_pop = ctrl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q != state_next || state_q == BK_IDLE) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Restoring division: one quotient bit enters the shift register per cycle.
	always_comb begin
		rem_shift = {rem_q, dq_q[DIVIDEND_W-1]};
		rem_ge    = (rem_shift >= {1'b0, div_q});
		rem_diff  = rem_shift - {1'b0, div_q};
		dq_next   = {dq_q[DIVIDEND_W-2:0], rem_ge};
	end

	// Digit-by-digit square root: two radicand bits in, one root bit out.
	always_comb begin
		sq_trial  = {sqrem_q, rad_q[RAD_W-1 -: 2]};
		sq_test   = {2'b00, root_q, 2'b01};
		sq_ge     = (sq_trial >= sq_test);
		sq_diff   = sq_trial - sq_test;
		root_next = {root_q[ROOT_W-2:0], sq_ge};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_div) begin
			dq_q  <= {in_sum, FRAC_BITS'(0)};
			rem_q <= '0;
			div_q <= in_count;
			ovf_q <= in_ovf;
		end else if (state_q == BK_DIV) begin
			dq_q  <= dq_next;
			rem_q <= rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
		end
		if (ctrl.load_sqrt) begin
			rad_q   <= (div_q == '0) ? '0 : RAD_W'(dq_next);
			sqrem_q <= '0;
			root_q  <= '0;
		end else if (state_q == BK_SQRT) begin
			rad_q   <= {rad_q[RAD_W-3:0], 2'b00};
			sqrem_q <= sq_ge ? sq_diff[SQREM_W-1:0] : sq_trial[SQREM_W-1:0];
			root_q  <= root_next;
		end
	end

	assign count_ext = (CNT_W + COUNT_W)'(div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_q.rms_value     <= (root_q > ROOT_W'({RMS_W{1'b1}})) ? {RMS_W{1'b1}}
			                       : root_q[RMS_W-1:0];
			out_q.element_count <= count_ext[COUNT_W-1:0];
			out_q.overflowed    <= ovf_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

endmodule

>>> rtl/vector_rms.sv
// ----------------------------------------------------------------------------
// vector_rms: root mean square of a streamed vector
// Accumulates squared samples up to the flagged last one and returns
// floor(sqrt(floor(sum * 65536 / count))) in unsigned Q.8 with the count.
// ----------------------------------------------------------------------------
//  Channel   Modport  Word type   Content
//  samples   sink     in_word_t   sample, is_last
//  results   source   out_word_t  rms_value, element_count, overflowed
//
// The front end takes one sample per cycle unless its last sample waits on a
// full queue; squaring and accumulation form a two-stage pipeline. Each finished
// vector enters a two-entry queue. The back end runs the shift-subtract divider,
// then the square root, then loads the output register, and takes no new vector
// until it is idle again. Reset clears all control state; a stalled result holds
// its register and the front keeps accepting until a finished vector meets a full queue.
module vector_rms #(
	parameter int unsigned MAX_LEN = vrms_pkg::MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	vrms_stream_if.sink   samples,
	vrms_stream_if.source results
);
	import vrms_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
	localparam int unsigned REC_W = SUM_W + CNT_W + 1;

	logic             push;
	logic             push_ready;
	logic [SUM_W-1:0] rec_sum;
	logic [CNT_W-1:0] rec_count;
	logic             rec_ovf;
	logic             rec_valid;
	logic             rec_pop;
	logic [REC_W-1:0] rec_data;

	vrms_front #(
		.MAX_LEN (MAX_LEN),
		.CNT_W   (CNT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push       (push),
		.push_ready (push_ready),
		.rec_sum    (rec_sum),
		.rec_count  (rec_count),
		.rec_ovf    (rec_ovf)
	);

	vrms_fifo #(
		.WIDTH (REC_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  ({rec_sum, rec_count, rec_ovf}),
		.pop_valid  (rec_valid),
		.pop        (rec_pop),
		.pop_data   (rec_data)
	);

	vrms_back #(
		.CNT_W (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_pop   (rec_pop),
		.rec_data  (rec_data),
		.results   (results)
	);

endmodule

>>> rtl/vrms_checker.sv
// ----------------------------------------------------------------------------
// vrms_checker: port-level assertions
// Watches the result port of vector_rms and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module vrms_checker #(
	parameter int unsigned MAX_LEN = vrms_pkg::MAX_LEN_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input vrms_pkg::out_word_t out_data
);
	import vrms_pkg::*;

	// A stalled result word keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Every result covers at least one sample.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.element_count != '0)
		else $error("result with zero element count");

	// An overflowed vector reports the saturated count.
	a_ovf_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflowed |-> out_data.element_count == COUNT_W'(MAX_LEN))
		else $error("overflow flagged without a saturated count");

	// The RMS never exceeds the largest sample magnitude.
	a_rms_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.rms_value <= RMS_W'(1 << (SAMPLE_BITS - 1 + 8)))
		else $error("RMS above full scale");

endmodule

bind vector_rms vrms_checker #(
	.MAX_LEN (MAX_LEN)
) u_vrms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for vector_rms
// Streams signed sample vectors into the block and predicts each result word
// (floor RMS in Q.8, element count, overflow flag) from a local copy of the
// accumulator state. Covers field extremes and a long run of random vectors,
// while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import vrms_pkg::*;

	localparam int unsigned MAX_LEN      = MAX_LEN_DEF;
	localparam int unsigned RANDOM_ITEMS = 1880;
	localparam int unsigned CYCLE_LIMIT  = 2000000;
	localparam int unsigned TAIL_CYCLES  = 300;
	localparam logic [63:0] SUM_LIMIT    = (64'd1 << SUM_W) - 64'd1;
	localparam logic [63:0] RMS_LIMIT    = (64'd1 << RMS_W) - 64'd1;

	logic clk = 1'b0;
	logic arst_n;

	vrms_stream_if #(.T(in_word_t))  samples_ch ();
	vrms_stream_if #(.T(out_word_t)) results_ch ();

	vector_rms #(
		.MAX_LEN(MAX_LEN)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.results(results_ch)
	);

	logic [63:0] acc_sum;
	int unsigned acc_count;
	logic        acc_ovf;
	out_word_t   rms_expected[$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned stall_left;
	logic        ready_calm;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if ({32'd0, trial} * {32'd0, trial} <= x)
				root = trial;
		end
		return root;
	endfunction

	task automatic accumulate_sample(input in_word_t w);
		longint      value;
		logic [63:0] square;
		logic [63:0] mean;
		logic [63:0] root;
		out_word_t   res;
		if (acc_count >= MAX_LEN) begin
			acc_ovf = 1'b1;
		end else begin
			value  = longint'($signed(w.sample));
			square = 64'(value * value);
			if (square > SUM_LIMIT - acc_sum)
				acc_sum = SUM_LIMIT;
			else
				acc_sum = acc_sum + square;
			acc_count++;
		end
		if (w.is_last) begin
			mean = '0;
			if (acc_count != 0)
				mean = {acc_sum[SUM_W-1:0], 16'd0} / 64'(acc_count);
			root = 64'(floor_sqrt(mean));
			if (root > RMS_LIMIT)
				root = RMS_LIMIT;
			res.rms_value     = root[RMS_W-1:0];
			res.element_count = acc_count[COUNT_W-1:0];
			res.overflowed    = acc_ovf;
			rms_expected.push_back(res);
			acc_sum   = '0;
			acc_count = 0;
			acc_ovf   = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && samples_ch.valid && samples_ch.ready)
			accumulate_sample(samples_ch.data);
	end

	always @(posedge clk) begin
		out_word_t want;
		out_word_t got;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			got = results_ch.data;
			if (rms_expected.size() == 0) begin
				$display("%0t: result word with none expected: rms %0d count %0d ovf %0d",
					$time, got.rms_value, got.element_count, got.overflowed);
				mismatches++;
			end else begin
				want = rms_expected.pop_front();
				if (got.rms_value !== want.rms_value) begin
					$display("%0t: rms_value expected %0d, actual %0d",
						$time, want.rms_value, got.rms_value);
					mismatches++;
				end
				if (got.element_count !== want.element_count) begin
					$display("%0t: element_count expected %0d, actual %0d",
						$time, want.element_count, got.element_count);
					mismatches++;
				end
				if (got.overflowed !== want.overflowed) begin
					$display("%0t: overflowed expected %0d, actual %0d",
						$time, want.overflowed, got.overflowed);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0)
			ready_calm <= ~ready_calm;
		if (stall_left != 0) begin
			results_ch.ready <= 1'b0;
			stall_left       <= stall_left - 1;
		end else begin
			results_ch.ready <= 1'b1;
			if (!ready_calm && $urandom_range(0, 5) == 0)
				stall_left <= pick_gap();
		end
	end

	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
		@(negedge clk);
		samples_ch.valid <= 1'b1;
		samples_ch.data  <= '{sample: value, is_last: last};
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
	endtask

	task automatic idle_samples(input int unsigned n);
		if (n != 0) begin
			@(negedge clk);
			samples_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send_paced(input logic signed [SAMPLE_BITS-1:0] value, input logic last,
			input logic gaps);
		send_word(value, last);
		if (gaps)
			idle_samples(pick_gap());
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int unsigned r;
		logic signed [SAMPLE_BITS-1:0] v;
		r = $urandom_range(0, 9);
		case (r)
			0: v = 16'sh7fff;
			1: v = 16'sh8000;
			2: begin
				v = SAMPLE_BITS'($urandom_range(0, 7));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = SAMPLE_BITS'($urandom());
		endcase
		return v;
	endfunction

	task automatic test_extremes();
		logic signed [SAMPLE_BITS-1:0] singles[5];
		singles = '{16'sd0, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd1};
		foreach (singles[i])
			send_paced(singles[i], 1'b1, 1'b1);
		send_paced(16'sh7fff, 1'b0, 1'b1);
		send_paced(16'sh8000, 1'b1, 1'b1);
		send_paced(16'sd1, 1'b0, 1'b1);
		send_paced(-16'sd1, 1'b0, 1'b1);
		send_paced(16'sd0, 1'b1, 1'b1);
		for (int i = 0; i < 4; i++)
			send_paced(16'sd0, i == 3, 1'b1);
		send_paced(16'sh5555, 1'b0, 1'b1);
		send_paced(16'shaaaa, 1'b1, 1'b1);
	endtask

	task automatic test_random();
		int unsigned sent;
		int unsigned len;
		int unsigned r;
		logic        gaps;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 8);
			else if (r < 95)
				len = $urandom_range(9, 64);
			else
				len = $urandom_range(65, 600);
			gaps = ($urandom_range(0, 3) != 0);
			for (int unsigned i = 0; i < len; i++)
				send_paced(pick_sample(), i == len - 1, gaps);
			sent += len;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.data  = '0;
		results_ch.ready = 1'b0;
		acc_sum          = '0;
		acc_count        = 0;
		acc_ovf          = 1'b0;
		mismatches       = 0;
		cycles           = 0;
		stall_left       = 0;
		ready_calm       = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_random();

		@(negedge clk);
		samples_ch.valid <= 1'b0;
		while (rms_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
rtl/vrms_pkg.sv
rtl/vrms_stream_if.sv
rtl/vrms_front.sv
rtl/vrms_fifo.sv
rtl/vrms_back.sv
rtl/vector_rms.sv
rtl/vrms_checker.sv
test/tb_top.sv
